// ===== design/srd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package srd_pkg;

  // operand and result width
  localparam int unsigned WIDTH = 8;

  // operand beat
  typedef struct packed {
    logic signed [WIDTH-1:0] dividend;
    logic signed [WIDTH-1:0] divisor;
  } op_t;

  // result beat
  typedef struct packed {
    logic signed [WIDTH-1:0] quotient;
    logic signed [WIDTH-1:0] remainder;
  } res_t;

  // state carried down the round pipeline
  typedef struct packed {
    logic [WIDTH:0]   a;     // partial remainder, one guard bit
    logic [WIDTH-1:0] q;     // dividend magnitude shifting into quotient
    logic [WIDTH-1:0] m;     // divisor magnitude
    logic             xneg;  // dividend negative: negate remainder
    logic             qneg;  // operands of strictly opposite sign: negate quotient
  } work_t;

endpackage

`default_nettype wire

// ===== design/signed_restoring_divider_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Signed 8-bit divider: each op beat (dividend, divisor) yields one res beat
// (quotient truncated toward zero, remainder carrying the dividend's sign).
// A zero divisor gives an all-ones quotient and the dividend as remainder;
// the most negative dividend over minus one wraps to the most negative value.
// The datapath is a pipeline of WIDTH+2 register stages: operand magnitude
// and sign capture, one stage per restoring round, then sign fixup into the
// output register. A new beat is taken every cycle while res_ready is high;
// backpressure on res_ready stalls every stage that has no bubble ahead of
// it, while a stage with a bubble ahead of it keeps moving to fill it.

module signed_restoring_divider_core (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 op_valid,
  output logic                op_ready,
  input  srd_pkg::op_t        op,
  output logic                res_valid,
  input  wire                 res_ready,
  output srd_pkg::res_t       res
);

  localparam int unsigned W = srd_pkg::WIDTH;

  logic           st_valid [0:W];
  logic           st_ready [0:W];
  srd_pkg::work_t st_data  [0:W];

  // operand capture
  srd_prep u_prep (
    .clk        (clk),
    .rst        (rst),
    .op_valid   (op_valid),
    .op_ready   (op_ready),
    .op         (op),
    .work_valid (st_valid[0]),
    .work_ready (st_ready[0]),
    .work       (st_data[0])
  );

  // one stage per quotient bit
  for (genvar i = 0; i < W; i++) begin : g_round
    srd_round u_round (
      .clk      (clk),
      .rst      (rst),
      .up_valid (st_valid[i]),
      .up_ready (st_ready[i]),
      .up       (st_data[i]),
      .dn_valid (st_valid[i+1]),
      .dn_ready (st_ready[i+1]),
      .dn       (st_data[i+1])
    );
  end

  // sign fixup and output register
  srd_fix u_fix (
    .clk        (clk),
    .rst        (rst),
    .work_valid (st_valid[W]),
    .work_ready (st_ready[W]),
    .work       (st_data[W]),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  // an open output means every stage can move
  a_ready_flow: assert property (@(posedge clk) disable iff (rst)
    res_ready |-> op_ready)
    else $error("pipeline blocked while output is open");

  // a beat taken at the input shows up in the capture stage next cycle
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (op_valid && op_ready && res_ready) |=> (st_valid[0] || $past(rst)))
    else $error("accepted beat lost at capture stage");

endmodule

`default_nettype wire

// ===== design/srd_prep.sv =====
`timescale 1ns / 1ps
`default_nettype none

module srd_prep (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 op_valid,
  output logic                op_ready,
  input  srd_pkg::op_t        op,
  output logic                work_valid,
  input  wire                 work_ready,
  output srd_pkg::work_t      work
);

  localparam int unsigned W = srd_pkg::WIDTH;

  logic           xneg;
  logic           yneg;
  logic           xpos;
  logic           ypos;
  srd_pkg::work_t work_next;

  // signs and magnitudes of the operands
  always_comb begin
    xneg = op.dividend[W-1];
    yneg = op.divisor[W-1];
    xpos = !xneg && (op.dividend != '0);
    ypos = !yneg && (op.divisor != '0);
    work_next.a    = '0;
    work_next.q    = xneg ? (W)'(-op.dividend) : op.dividend;
    work_next.m    = yneg ? (W)'(-op.divisor) : op.divisor;
    work_next.xneg = xneg;
    work_next.qneg = (xneg && ypos) || (xpos && yneg);
  end

  assign op_ready = !work_valid || work_ready;

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      work_valid <= 1'b0;
    end else if (op_ready) begin
      work_valid <= op_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (op_ready && op_valid) begin
      work <= work_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/srd_round.sv =====
`timescale 1ns / 1ps
`default_nettype none

module srd_round (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 up_valid,
  output logic                up_ready,
  input  srd_pkg::work_t      up,
  output logic                dn_valid,
  input  wire                 dn_ready,
  output srd_pkg::work_t      dn
);

  localparam int unsigned W = srd_pkg::WIDTH;

  logic [W:0]     a_sh;
  logic [W:0]     trial;
  srd_pkg::work_t dn_next;

  // one restoring round: shift, trial subtract, keep or restore
  always_comb begin
    a_sh    = {up.a[W-1:0], up.q[W-1]};
    trial   = a_sh - {1'b0, up.m};
    dn_next = up;
    dn_next.q = {up.q[W-2:0], 1'b0};
    if (!trial[W]) begin
      dn_next.a    = trial;
      dn_next.q[0] = 1'b1;
    end else begin
      dn_next.a = a_sh;
    end
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn <= dn_next;
    end
  end

  // partial remainder always stays below a nonzero divisor
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    (dn_valid && (dn.m != '0)) |-> (dn.a < {1'b0, dn.m}))
    else $error("partial remainder not below divisor");

  // guard bit never survives a round
  a_guard_clear: assert property (@(posedge clk) disable iff (rst)
    dn_valid |-> !dn.a[W])
    else $error("partial remainder guard bit set");

endmodule

`default_nettype wire

// ===== design/srd_fix.sv =====
`timescale 1ns / 1ps
`default_nettype none

module srd_fix (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 work_valid,
  output logic                work_ready,
  input  srd_pkg::work_t      work,
  output logic                res_valid,
  input  wire                 res_ready,
  output srd_pkg::res_t       res
);

  localparam int unsigned W = srd_pkg::WIDTH;

  srd_pkg::res_t res_next;

  // apply signs, wrapping to the result width
  always_comb begin
    res_next.quotient  = work.qneg ? (W)'(-work.q) : work.q;
    res_next.remainder = work.xneg ? (W)'(-work.a[W-1:0]) : work.a[W-1:0];
  end

  assign work_ready = !res_valid || res_ready;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (work_ready) begin
      res_valid <= work_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (work_ready && work_valid) begin
      res <= res_next;
    end
  end

  // zero divisor: every round succeeds, quotient magnitude is all ones
  a_div_zero_ones: assert property (@(posedge clk) disable iff (rst)
    (work_valid && (work.m == '0)) |-> (work.q == '1) && !work.qneg)
    else $error("zero divisor did not give all-ones quotient");

  // remainder magnitude fits in the result width
  a_rem_fits: assert property (@(posedge clk) disable iff (rst)
    work_valid |-> !work.a[W])
    else $error("final remainder overflows");

endmodule

`default_nettype wire

// ===== test/signed_restoring_divider_core_test.sv =====
`timescale 1ns / 1ps

module signed_restoring_divider_core_test;

  localparam int DIR_ROWS = 23;
  localparam int RAND_ITEMS = 650;
  localparam int PIPE_LAT = srd_pkg::WIDTH + 2;
  localparam int HOLD_CYCLES = 40;
  localparam int CYCLE_LIMIT = 100000;

  // one directed row: operands, and the answer when it is obvious
  typedef struct packed {
    srd_pkg::op_t  op;
    bit            known;
    srd_pkg::res_t want;
  } row_t;

  logic          clk = 1'b0;
  logic          rst;
  logic          op_valid;
  logic          op_ready;
  srd_pkg::op_t  op;
  logic          res_valid;
  logic          res_ready;
  srd_pkg::res_t res;

  srd_pkg::res_t quot_rem_due[$];  // quotient/remainder pairs still owed by the core
  srd_pkg::res_t offer_want;       // answer for the op beat currently offered
  int   mismatches = 0;
  int   cycles = 0;
  int   idle_pct = 0;
  bit   hold_req = 1'b0;

  signed_restoring_divider_core u_top (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (op_valid),
    .op_ready  (op_ready),
    .op        (op),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // restoring division on magnitudes, guard bit on the partial remainder
  function automatic srd_pkg::res_t restoring_divide(input srd_pkg::op_t v);
    logic [srd_pkg::WIDTH-1:0] x, y, q, m, r;
    logic [srd_pkg::WIDTH:0]   a, trial;
    logic                      xneg, yneg, xpos, ypos;
    srd_pkg::res_t             out;
    int                        i;
    x = v.dividend;
    y = v.divisor;
    xneg = x[srd_pkg::WIDTH-1];
    yneg = y[srd_pkg::WIDTH-1];
    xpos = !xneg && (x != '0);
    ypos = !yneg && (y != '0);
    q = xneg ? (~x + 1'b1) : x;
    m = yneg ? (~y + 1'b1) : y;
    a = '0;
    for (i = 0; i < srd_pkg::WIDTH; i++) begin
      a = {a[srd_pkg::WIDTH-1:0], q[srd_pkg::WIDTH-1]};
      q = {q[srd_pkg::WIDTH-2:0], 1'b0};
      trial = a - {1'b0, m};
      if (!trial[srd_pkg::WIDTH]) begin
        a = trial;
        q[0] = 1'b1;
      end
    end
    r = a[srd_pkg::WIDTH-1:0];
    if (xneg) r = ~r + 1'b1;
    // quotient sign flips only for strictly opposite signs
    if ((xneg && ypos) || (xpos && yneg)) q = ~q + 1'b1;
    out.quotient = q;
    out.remainder = r;
    return out;
  endfunction

  function automatic row_t mk(input int a, input int b, input bit known,
                              input int q, input int r);
    row_t row;
    row.op.dividend = a[srd_pkg::WIDTH-1:0];
    row.op.divisor = b[srd_pkg::WIDTH-1:0];
    row.known = known;
    row.want.quotient = q[srd_pkg::WIDTH-1:0];
    row.want.remainder = r[srd_pkg::WIDTH-1:0];
    return row;
  endfunction

  // directed table: extremes, zero divisor, wrap, all sign pairings
  function automatic row_t dir_row(input int i);
    case (i)
      0:       return mk(0, 0, 1'b1, -1, 0);         // zero over zero
      1:       return mk(7, 0, 1'b1, -1, 7);         // zero divisor
      2:       return mk(-128, 0, 1'b1, -1, -128);
      3:       return mk(127, 0, 1'b1, -1, 127);
      4:       return mk(-128, -1, 1'b1, -128, 0);   // quotient wraps
      5:       return mk(127, 1, 1'b1, 127, 0);
      6:       return mk(-128, 1, 1'b1, -128, 0);
      7:       return mk(127, -1, 1'b1, -127, 0);
      8:       return mk(0, 5, 1'b1, 0, 0);
      9:       return mk(0, -5, 1'b1, 0, 0);
      10:      return mk(7, 2, 1'b1, 3, 1);
      11:      return mk(-7, 2, 1'b1, -3, -1);
      12:      return mk(7, -2, 1'b1, -3, 1);
      13:      return mk(-7, -2, 1'b1, 3, -1);
      14:      return mk(-128, -128, 1'b1, 1, 0);
      15:      return mk(127, 127, 1'b1, 1, 0);
      16:      return mk(-128, 127, 1'b0, 0, 0);
      17:      return mk(127, -128, 1'b0, 0, 0);
      18:      return mk(-1, -128, 1'b0, 0, 0);
      19:      return mk(100, 7, 1'b0, 0, 0);
      20:      return mk(-100, -7, 1'b0, 0, 0);
      21:      return mk(85, -86, 1'b0, 0, 0);
      22:      return mk(-86, 85, 1'b0, 0, 0);
      default: return mk(0, 0, 1'b1, -1, 0);
    endcase
  endfunction

  function automatic logic [srd_pkg::WIDTH-1:0] corner_val();
    case ($urandom_range(0, 4))
      0:       return {1'b1, {(srd_pkg::WIDTH-1){1'b0}}};
      1:       return {srd_pkg::WIDTH{1'b1}};
      2:       return '0;
      3:       return {{(srd_pkg::WIDTH-1){1'b0}}, 1'b1};
      default: return {1'b0, {(srd_pkg::WIDTH-1){1'b1}}};
    endcase
  endfunction

  function automatic srd_pkg::op_t rand_op();
    logic [31:0]  bits;
    srd_pkg::op_t v;
    bits = $urandom();
    v.dividend = bits[srd_pkg::WIDTH-1:0];
    v.divisor = bits[2*srd_pkg::WIDTH-1:srd_pkg::WIDTH];
    case ($urandom_range(0, 9))
      0: v.divisor = '0;
      1: begin
        v.dividend = corner_val();
        v.divisor = corner_val();
      end
      // small divisor magnitude, either sign
      2, 3: v.divisor = {{(srd_pkg::WIDTH-3){1'b0}}, bits[18:16]}
                        ^ {srd_pkg::WIDTH{bits[19]}};
      default: ;
    endcase
    return v;
  endfunction

  task automatic flag_mismatch(input string what, input srd_pkg::res_t got,
                               input srd_pkg::res_t want);
    $display("[%0t] %s: got q=%0d r=%0d, want q=%0d r=%0d", $realtime, what,
             got.quotient, got.remainder, want.quotient, want.remainder);
    mismatches++;
  endtask

  // offer one op beat, with an optional idle burst ahead of it
  task automatic offer(input srd_pkg::op_t v, input srd_pkg::res_t want);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      op_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    op_valid <= 1'b1;
    op <= v;
    offer_want <= want;
    @(posedge clk);
    while (!op_ready) @(posedge clk);
  endtask

  // scoreboard: check result beats, then log newly accepted op beats
  always @(posedge clk) begin
    if (!rst) begin
      if (res_valid && res_ready) begin
        if (quot_rem_due.size() == 0) begin
          flag_mismatch("result beat with nothing owed", res, '0);
        end else begin
          if (res.quotient !== quot_rem_due[0].quotient)
            flag_mismatch("quotient", res, quot_rem_due[0]);
          if (res.remainder !== quot_rem_due[0].remainder)
            flag_mismatch("remainder", res, quot_rem_due[0]);
          void'(quot_rem_due.pop_front());
        end
      end
      if (op_valid && op_ready) quot_rem_due.push_back(offer_want);
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        res_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        res_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        res_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // runaway guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("signed_restoring_divider_core_test: errors");
      $finish;
    end
  end

  // stimulus
  initial begin
    row_t         row;
    srd_pkg::op_t v;
    int           i;
    int           n;
    rst <= 1'b1;
    op_valid <= 1'b0;
    op <= '0;
    offer_want <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    idle_pct = 20;
    for (i = 0; i < DIR_ROWS; i++) begin
      row = dir_row(i);
      offer(row.op, row.known ? row.want : restoring_divide(row.op));
    end

    for (n = 0; n < RAND_ITEMS; n++) begin
      if (n % 50 == 0) begin
        case ($urandom_range(0, 2))
          0:       idle_pct = 0;
          1:       idle_pct = 10;
          default: idle_pct = 35;
        endcase
        // back up the pipe while ops keep coming
        if (n == 250) begin
          idle_pct = 0;
          hold_req = 1'b1;
        end
        if (n >= RAND_ITEMS - 100) idle_pct = 0;
      end
      v = rand_op();
      offer(v, restoring_divide(v));
    end
    op_valid <= 1'b0;

    while (quot_rem_due.size() != 0) @(posedge clk);
    repeat (4 * PIPE_LAT) @(posedge clk);
    if (mismatches == 0) begin
      $display("signed_restoring_divider_core_test: clean");
    end else begin
      $display("signed_restoring_divider_core_test: errors");
    end
    $finish;
  end

endmodule
